// ===== rtl/byte_alu_with_bcd_flags_macros.svh =====
// ----------------------------------------------------------------------------
// Byte ALU assertion macros
// Shared assertion macros for the byte ALU; the clock is i_clk and the reset
// is i_rst_n in every module that uses them.
// ----------------------------------------------------------------------------
`ifndef BYTE_ALU_WITH_BCD_FLAGS_MACROS_SVH
`define BYTE_ALU_WITH_BCD_FLAGS_MACROS_SVH

// Checked only while out of reset.
`define BALU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define BALU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/balu_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte ALU package
// Operation codes, item types and the decimal adjust constants.
// ----------------------------------------------------------------------------
package balu_pkg;

    typedef enum logic [3:0] {
        KIND_ADD     = 4'd0,
        KIND_SUB     = 4'd1,
        KIND_BCD_ADD = 4'd2,
        KIND_BCD_SUB = 4'd3,
        KIND_AND     = 4'd4,
        KIND_OR      = 4'd5,
        KIND_XOR     = 4'd6,
        KIND_BIT     = 4'd7,
        KIND_ASL     = 4'd8,
        KIND_LSR     = 4'd9,
        KIND_ROL     = 4'd10,
        KIND_ROR     = 4'd11,
        KIND_CMP     = 4'd12
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  operand_a;
        logic [7:0]  operand_b;
        logic        use_carry;
        logic        carry_in;
        logic        zero_in;
        logic        negative_in;
        logic        overflow_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  result;
        logic        result_written;
        logic        carry_out;
        logic        zero_out;
        logic        negative_out;
        logic        overflow_out;
    } t_out_item;

    localparam logic [3:0] DIGIT_MAX    = 4'h9;
    localparam logic [9:0] BYTE_BCD_MAX = 10'h099;
    localparam logic [7:0] LO_ADJUST    = 8'h06;
    localparam logic [7:0] HI_ADJUST    = 8'h60;

endpackage

// ===== rtl/balu_if.sv =====
// ----------------------------------------------------------------------------
// Byte ALU channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface balu_in_if;
    logic                valid;
    logic                ready;
    balu_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface balu_out_if;
    logic                valid;
    logic                ready;
    balu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/balu_core.sv =====
// ----------------------------------------------------------------------------
// Byte ALU datapath
// Computes the result byte and the new flags for one operation item.
// ----------------------------------------------------------------------------
module balu_core (
    input  balu_pkg::t_in_item  i_item,
    output balu_pkg::t_out_item o_item
);

    logic [7:0] a;
    logic [7:0] b;
    logic       cin;
    logic [8:0] bin_sum;
    logic [8:0] sub_sum;
    logic [9:0] bcd_raw;
    logic [9:0] bcd_lo;
    logic [9:0] bcd_sum;
    logic [4:0] lo_sum;
    logic [4:0] lo_need;
    logic       lo_borrow;
    logic [7:0] dsub;
    logic [7:0] cmp_diff;
    logic [7:0] res;

    assign a        = i_item.operand_a;
    assign b        = i_item.operand_b;
    assign cin      = i_item.use_carry & i_item.carry_in;
    assign bin_sum  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign sub_sum  = {1'b0, a} + {1'b0, ~b} + {8'd0, cin};
    assign lo_sum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign bcd_raw  = {1'b0, bin_sum};
    assign bcd_lo   = (lo_sum > {1'b0, balu_pkg::DIGIT_MAX})
                      ? bcd_raw + {2'd0, balu_pkg::LO_ADJUST} : bcd_raw;
    assign bcd_sum  = (bcd_lo > balu_pkg::BYTE_BCD_MAX)
                      ? bcd_lo + {2'd0, balu_pkg::HI_ADJUST} : bcd_lo;
    assign lo_need  = {1'b0, b[3:0]} + {4'd0, ~cin};
    assign lo_borrow = {1'b0, a[3:0]} < lo_need;
    assign dsub     = sub_sum[7:0]
                      - (lo_borrow ? balu_pkg::LO_ADJUST : 8'd0)
                      - (sub_sum[8] ? 8'd0 : balu_pkg::HI_ADJUST);
    assign cmp_diff = a - b;

    always_comb begin
        res = 8'd0;
        o_item.result_written = 1'b1;
        o_item.carry_out      = i_item.carry_in;
        o_item.zero_out       = i_item.zero_in;
        o_item.negative_out   = i_item.negative_in;
        o_item.overflow_out   = i_item.overflow_in;
        unique case (i_item.kind)
            balu_pkg::KIND_ADD: begin
                res = bin_sum[7:0];
                o_item.carry_out    = bin_sum[8];
                o_item.overflow_out = (a[7] ^ res[7]) & (b[7] ^ res[7]);
            end
            balu_pkg::KIND_SUB: begin
                res = sub_sum[7:0];
                o_item.carry_out    = sub_sum[8];
                o_item.overflow_out = (a[7] ^ b[7]) & (a[7] ^ res[7]);
            end
            balu_pkg::KIND_BCD_ADD: begin
                res = bcd_sum[7:0];
                o_item.carry_out = |bcd_sum[9:8];
            end
            balu_pkg::KIND_BCD_SUB: begin
                res = dsub;
                o_item.carry_out = sub_sum[8];
            end
            balu_pkg::KIND_AND: res = a & b;
            balu_pkg::KIND_OR:  res = a | b;
            balu_pkg::KIND_XOR: res = a ^ b;
            balu_pkg::KIND_BIT: begin
                o_item.result_written = 1'b0;
                o_item.overflow_out   = b[6];
            end
            balu_pkg::KIND_ASL: begin
                res = {a[6:0], 1'b0};
                o_item.carry_out = a[7];
            end
            balu_pkg::KIND_LSR: begin
                res = {1'b0, a[7:1]};
                o_item.carry_out = a[0];
            end
            balu_pkg::KIND_ROL: begin
                res = {a[6:0], i_item.carry_in};
                o_item.carry_out = a[7];
            end
            balu_pkg::KIND_ROR: begin
                res = {i_item.carry_in, a[7:1]};
                o_item.carry_out = a[0];
            end
            balu_pkg::KIND_CMP: begin
                o_item.result_written = 1'b0;
                o_item.carry_out      = a >= b;
            end
            default: begin
                o_item.result_written = 1'b0;
            end
        endcase

        // Bit test and compare set N and Z from their own rules.
        if (i_item.kind == balu_pkg::KIND_BIT) begin
            o_item.zero_out     = (a & b) == 8'd0;
            o_item.negative_out = b[7];
        end else if (i_item.kind == balu_pkg::KIND_CMP) begin
            o_item.zero_out     = a == b;
            o_item.negative_out = cmp_diff[7];
        end else if (o_item.result_written) begin
            o_item.zero_out     = res == 8'd0;
            o_item.negative_out = res[7];
        end
        o_item.result = res;
    end

endmodule

// ===== rtl/balu_stage.sv =====
// ----------------------------------------------------------------------------
// Byte ALU register stage
// One valid/ready register slice that takes a new item in every cycle in
// which its held item leaves or it is empty.
// ----------------------------------------------------------------------------
`include "byte_alu_with_bcd_flags_macros.svh"

module balu_stage #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  T     i_data,
    output logic o_valid,
    input  logic i_ready,
    output T     o_data
);

    logic r_valid;
    logic n_valid;
    T     r_data;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = i_valid || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    `BALU_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "Stage holds an item after reset.")
    `BALU_ASSERT(a_accept_fills, i_valid && o_ready |=> o_valid, "Accepted item was lost.")
    `BALU_ASSERT(a_stall_only_full, !o_ready |-> o_valid && !i_ready, "Stage stalls without cause.")

endmodule

// ===== rtl/byte_alu_with_bcd_flags.sv =====
// ----------------------------------------------------------------------------
// Byte ALU with decimal mode flags
// Eight-bit processor ALU: binary and decimal add and subtract, logic
// operations, bit test, shifts, rotates and compare, with N, V, Z, C flags.
//
// Channel    Dir   Item
// i_op       in    operation, two operand bytes, use-carry, N V Z C flags
// o_res      out   result byte, result-written bit, new N V Z C flags
//
// An item is accepted in every cycle unless a stall fills both registers;
// it passes through the input register and then the result register.
// The only logic between them is the single-pass ALU datapath.
// Reset empties both registers. A stalled result register holds its item
// and the input side keeps accepting until both registers are full.
// ----------------------------------------------------------------------------
`include "byte_alu_with_bcd_flags_macros.svh"

module byte_alu_with_bcd_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    balu_in_if.sink     i_op,
    balu_out_if.source  o_res
);

    logic                op_valid;
    logic                op_ready;
    balu_pkg::t_in_item  op_item;
    balu_pkg::t_out_item alu_item;

    balu_stage #(
        .T (balu_pkg::t_in_item)
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_op.valid),
        .o_ready (i_op.ready),
        .i_data  (i_op.data),
        .o_valid (op_valid),
        .i_ready (op_ready),
        .o_data  (op_item)
    );

    balu_core u_core (
        .i_item (op_item),
        .o_item (alu_item)
    );

    balu_stage #(
        .T (balu_pkg::t_out_item)
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (op_valid),
        .o_ready (op_ready),
        .i_data  (alu_item),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (o_res.data)
    );

    `BALU_ASSERT(a_no_byte_is_zero, o_res.valid && !o_res.data.result_written |-> o_res.data.result == 8'd0, "Result byte set without a write.")

endmodule
